@@ rtl/vector3_normalise_assert.svh @@
// ----------------------------------------------------------------------------
// vector3_normalise assertion macros
// Macros for the concurrent checks in the vector normalizer.
// The checks are left out when the design is synthesized.
// ----------------------------------------------------------------------------
`ifndef VECTOR3_NORMALISE_ASSERT_SVH
`define VECTOR3_NORMALISE_ASSERT_SVH
`ifndef SYNTHESIS
`define V3N_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("vector3_normalise check failed");
`define V3N_ASSERT_IMP(lbl, ante, cons) \
  `V3N_ASSERT(lbl, (ante) |-> (cons))
`else
`define V3N_ASSERT(lbl, prop)
`define V3N_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

@@ rtl/v3n_pkg.sv @@
// ----------------------------------------------------------------------------
// v3n_pkg
// Widths and constants shared by the vector normalizer modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package v3n_pkg;
  localparam int unsigned CompW      = 16;
  localparam int unsigned MagW       = 16;
  localparam int unsigned SqW        = 32;
  localparam int unsigned SumW       = 32;
  localparam int unsigned AccW       = 66;
  localparam int unsigned QW         = 15;
  localparam int unsigned QStages    = 15;
  localparam int unsigned RootW      = 16;
  localparam int unsigned SqrtStages = 16;
  localparam int unsigned PipeDepth  = 16;
  localparam int unsigned Q214One    = 16384;
  localparam int unsigned FracShift  = 30;
endpackage
`default_nettype wire

@@ rtl/v3n_isqrt.sv @@
// ----------------------------------------------------------------------------
// v3n_isqrt
// Pipelined floor square root of a 32-bit sum, one result bit per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module v3n_isqrt (
  input  wire logic                      clk_i,
  input  wire logic [v3n_pkg::SumW-1:0]  s_i,
  output logic      [v3n_pkg::RootW-1:0] root_o
);
  import v3n_pkg::*;

  localparam int unsigned SqAccW = SumW + 2;

  logic [RootW-1:0]  root_q [SqrtStages+1];
  logic [SqAccW-1:0] sq_q   [SqrtStages+1];
  logic [SumW-1:0]   s_q    [SqrtStages+1];

  always_comb begin
    root_q[0] = '0;
    sq_q[0]   = '0;
    s_q[0]    = s_i;
  end

  for (genvar j = 0; j < SqrtStages; j++) begin : g_stage
    localparam int unsigned K = SqrtStages - 1 - j;
    logic [SqAccW-1:0] sq_d;
    logic              take;

    always_comb begin
      sq_d = sq_q[j] + (SqAccW'(root_q[j]) << (K + 1)) + (SqAccW'(1) << (2 * K));
      take = sq_d <= SqAccW'(s_q[j]);
    end

    always_ff @(posedge clk_i) begin
      s_q[j+1] <= s_q[j];
      if (take) begin
        root_q[j+1] <= root_q[j] | (RootW'(1) << K);
        sq_q[j+1]   <= sq_d;
      end else begin
        root_q[j+1] <= root_q[j];
        sq_q[j+1]   <= sq_q[j];
      end
    end
  end

  assign root_o = root_q[SqrtStages];
endmodule
`default_nettype wire

@@ rtl/v3n_scale_lane.sv @@
// ----------------------------------------------------------------------------
// v3n_scale_lane
// Pipelined search for the rounded magnitude of one unit component.
// Each stage decides one quotient bit with shift-and-add updates only.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "vector3_normalise_assert.svh"
module v3n_scale_lane (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic [v3n_pkg::SqW-1:0]  sq_i,
  input  wire logic [v3n_pkg::SumW-1:0] s_i,
  output logic      [v3n_pkg::QW-1:0]   q_o
);
  import v3n_pkg::*;

  logic [QW-1:0]   q_q  [QStages+1];
  logic [AccW-1:0] q1_q [QStages+1];
  logic [AccW-1:0] q2_q [QStages+1];
  logic [AccW-1:0] fa_q [QStages+1];
  logic [SumW-1:0] s_q  [QStages+1];

  always_ff @(posedge clk_i) begin
    q_q[0]  <= '0;
    q1_q[0] <= '0;
    q2_q[0] <= '0;
    fa_q[0] <= AccW'(sq_i) << FracShift;
    s_q[0]  <= s_i;
  end

  for (genvar j = 0; j < QStages; j++) begin : g_stage
    localparam int unsigned K = QStages - 1 - j;
    logic [AccW-1:0] s_ext;
    logic [AccW-1:0] q1_d;
    logic [AccW-1:0] q2_d;
    logic [AccW-1:0] t2_s;
    logic            take;

    always_comb begin
      s_ext = AccW'(s_q[j]);
      q1_d  = q1_q[j] + (s_ext << K);
      q2_d  = q2_q[j] + (q1_q[j] << (K + 1)) + (s_ext << (2 * K));
      t2_s  = (q2_d << 2) - (q1_d << 2) + s_ext;
      take  = t2_s <= fa_q[j];
    end

    always_ff @(posedge clk_i) begin
      s_q[j+1]  <= s_q[j];
      fa_q[j+1] <= fa_q[j];
      if (take) begin
        q_q[j+1]  <= q_q[j] | (QW'(1) << K);
        q1_q[j+1] <= q1_d;
        q2_q[j+1] <= q2_d;
      end else begin
        q_q[j+1]  <= q_q[j];
        q1_q[j+1] <= q1_q[j];
        q2_q[j+1] <= q2_q[j];
      end
    end
  end

  assign q_o = q_q[QStages];

  `V3N_ASSERT_IMP(a_q_bound, s_q[QStages] != '0 && fa_q[QStages] <= (AccW'(s_q[QStages]) << FracShift), q_o <= QW'(Q214One))
  `V3N_ASSERT_IMP(a_zero_mag, fa_q[QStages] == '0 && s_q[QStages] != '0, q_o == '0)
  `V3N_ASSERT(a_fa_pass, $past(fa_q[0]) == fa_q[1] || !$past(rst_ni))
endmodule
`default_nettype wire

@@ rtl/vector3_normalise.sv @@
// Vectors no longer than epsilon pass through, shifted to Q2.14 and saturated.
// Throughput: one item per cycle; busy_o is always low, so start_i may be held high.
// The depth is set by the 16-stage square root and 15-stage quotient search lanes.
// Results appear for one cycle with done_o; the receiver cannot stall.
// rst_ni clears all valid bits and sets epsilon to zero.
// ----------------------------------------------------------------------------
// vector3_normalise
// Normalizes a Q8.8 3D vector to Q2.14 unit components and reports its length.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "vector3_normalise_assert.svh"
module vector3_normalise (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  output logic                             busy_o,
  input  wire logic                        eps_we_i,
  input  wire logic [v3n_pkg::CompW-1:0]   eps_wdata_i,
  input  wire logic signed [v3n_pkg::CompW-1:0] x_in_i,
  input  wire logic signed [v3n_pkg::CompW-1:0] y_in_i,
  input  wire logic signed [v3n_pkg::CompW-1:0] z_in_i,
  output logic                             done_o,
  output logic signed [v3n_pkg::CompW-1:0] unit_x_o,
  output logic signed [v3n_pkg::CompW-1:0] unit_y_o,
  output logic signed [v3n_pkg::CompW-1:0] unit_z_o,
  output logic      [v3n_pkg::RootW-1:0]   length_o,
  output logic                             was_scaled_o
);
  import v3n_pkg::*;

  logic [CompW-1:0] eps_q;
  logic [SqW-1:0]   eps_sq_q;

  logic signed [CompW-1:0] c1_q [3];
  logic                    v1_q;
  logic signed [CompW-1:0] c2_q [3];
  logic [SqW-1:0]          sq2_q [3];
  logic                    v2_q;
  logic signed [CompW-1:0] c3_q [3];
  logic [SqW-1:0]          sq3_q [3];
  logic [SumW-1:0]         s3_q;
  logic                    sc3_q;
  logic                    v3_q;

  logic signed [CompW-1:0] cd_q  [PipeDepth][3];
  logic                    scd_q [PipeDepth];
  logic                    vd_q  [PipeDepth];

  logic [QW-1:0]    q_w [3];
  logic [RootW-1:0] root_w;
  logic [MagW-1:0]  mag_w [3];
  logic [SumW+1:0]  sum_w;
  logic signed [CompW-1:0] unit_d [3];

  logic signed [CompW-1:0] unit_q [3];
  logic [RootW-1:0]        len_q;
  logic                    scaled_q;
  logic                    done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q    <= '0;
      eps_sq_q <= '0;
    end else if (eps_we_i) begin
      eps_q    <= eps_wdata_i;
      eps_sq_q <= SqW'(eps_wdata_i) * SqW'(eps_wdata_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      for (int i = 0; i < PipeDepth; i++) begin
        vd_q[i] <= 1'b0;
      end
      done_q <= 1'b0;
    end else begin
      v1_q  <= start_i;
      v2_q  <= v1_q;
      v3_q  <= v2_q;
      vd_q[0] <= v3_q;
      for (int i = 1; i < PipeDepth; i++) begin
        vd_q[i] <= vd_q[i-1];
      end
      done_q <= vd_q[PipeDepth-1];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_w[i] = c1_q[i][CompW-1] ? MagW'(-c1_q[i]) : MagW'(c1_q[i]);
    end
    sum_w = (SumW+2)'(sq2_q[0]) + (SumW+2)'(sq2_q[1]) + (SumW+2)'(sq2_q[2]);
  end

  always_ff @(posedge clk_i) begin
    c1_q[0] <= x_in_i;
    c1_q[1] <= y_in_i;
    c1_q[2] <= z_in_i;
    for (int i = 0; i < 3; i++) begin
      c2_q[i]  <= c1_q[i];
      sq2_q[i] <= SqW'(mag_w[i]) * SqW'(mag_w[i]);
      c3_q[i]  <= c2_q[i];
      sq3_q[i] <= sq2_q[i];
      cd_q[0][i] <= c3_q[i];
    end
    s3_q   <= SumW'(sum_w);
    sc3_q  <= SumW'(sum_w) > eps_sq_q;
    scd_q[0] <= sc3_q;
    for (int d = 1; d < PipeDepth; d++) begin
      scd_q[d] <= scd_q[d-1];
      for (int i = 0; i < 3; i++) begin
        cd_q[d][i] <= cd_q[d-1][i];
      end
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_lane
    v3n_scale_lane u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .sq_i   (sq3_q[l]),
      .s_i    (s3_q),
      .q_o    (q_w[l])
    );
  end

  v3n_isqrt u_isqrt (
    .clk_i  (clk_i),
    .s_i    (s3_q),
    .root_o (root_w)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (scd_q[PipeDepth-1]) begin
        unit_d[i] = cd_q[PipeDepth-1][i][CompW-1] ? -$signed({1'b0, q_w[i]})
                                                  : $signed({1'b0, q_w[i]});
      end else if ($signed(cd_q[PipeDepth-1][i]) > $signed(CompW'(511))) begin
        unit_d[i] = $signed({1'b0, {(CompW-1){1'b1}}});
      end else if ($signed(cd_q[PipeDepth-1][i]) < $signed(-CompW'(512))) begin
        unit_d[i] = $signed({1'b1, {(CompW-1){1'b0}}});
      end else begin
        unit_d[i] = cd_q[PipeDepth-1][i] <<< 6;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      unit_q[i] <= unit_d[i];
    end
    len_q    <= root_w;
    scaled_q <= scd_q[PipeDepth-1];
  end

  assign busy_o       = 1'b0;
  assign done_o       = done_q;
  assign unit_x_o     = unit_q[0];
  assign unit_y_o     = unit_q[1];
  assign unit_z_o     = unit_q[2];
  assign length_o     = len_q;
  assign was_scaled_o = scaled_q;

  `V3N_ASSERT_IMP(a_scaled_len, done_o && was_scaled_o, length_o >= eps_q)
  `V3N_ASSERT_IMP(a_pass_len, done_o && !was_scaled_o, length_o <= eps_q)
  `V3N_ASSERT_IMP(a_unit_range, done_o && was_scaled_o, unit_x_o <= $signed(CompW'(Q214One)) && unit_x_o >= -$signed(CompW'(Q214One)))
endmodule
`default_nettype wire

@@ test/vector3_normalise_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector3_normalise_test
// Self-checking bench for the vector normalizer. A directed table covers the
// zero vector, the component extremes, the threshold tie and pass-through
// saturation; random bursts of vectors follow under several thresholds. Every
// result is checked against a typed row or an in-bench model of length and unit vector.
// ----------------------------------------------------------------------------
module vector3_normalise_test;
  import v3n_pkg::*;

  typedef struct packed {
    logic signed [CompW-1:0] ux;
    logic signed [CompW-1:0] uy;
    logic signed [CompW-1:0] uz;
    logic [RootW-1:0]        len;
    logic                    scaled;
  } unit_res_t;

  typedef struct {
    int eps;
    int x;
    int y;
    int z;
    bit typed;
    int ux;
    int uy;
    int uz;
    int len;
    int sc;
  } vec_row_t;

  localparam int NumRows = 14;
  localparam int Latency = 20;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic eps_we_i = 1'b0;
  logic [CompW-1:0] eps_wdata_i = '0;
  logic signed [CompW-1:0] x_in_i = '0;
  logic signed [CompW-1:0] y_in_i = '0;
  logic signed [CompW-1:0] z_in_i = '0;
  logic busy_o;
  logic done_o;
  logic signed [CompW-1:0] unit_x_o;
  logic signed [CompW-1:0] unit_y_o;
  logic signed [CompW-1:0] unit_z_o;
  logic [RootW-1:0] length_o;
  logic was_scaled_o;

  logic [CompW-1:0] eps_model = '0;
  logic use_typed = 1'b0;
  unit_res_t typed_res = '0;
  unit_res_t unit_q[$];
  int errors = 0;

  vec_row_t rows [NumRows] = '{
    '{0, 0, 0, 0, 1, 0, 0, 0, 0, 0},
    '{0, 256, 0, 0, 1, 16384, 0, 0, 256, 1},
    '{0, -32768, 0, 0, 1, -16384, 0, 0, 32768, 1},
    '{0, 0, 0, -256, 1, 0, 0, -16384, 256, 1},
    '{0, 32767, 32767, 32767, 0, 0, 0, 0, 0, 0},
    '{0, -32768, -32768, -32768, 0, 0, 0, 0, 0, 0},
    '{0, 1, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, 100, -200, 300, 0, 0, 0, 0, 0, 0},
    '{65535, 1, -1, 0, 1, 64, -64, 0, 1, 0},
    '{65535, 512, -512, 0, 1, 32767, -32768, 0, 724, 0},
    '{65535, 32767, -32768, 32767, 0, 0, 0, 0, 0, 0},
    '{256, 256, 0, 0, 1, 16384, 0, 0, 256, 0},
    '{256, 256, 1, 0, 0, 0, 0, 0, 0, 0},
    '{256, 0, -181, 181, 0, 0, 0, 0, 0, 0}
  };

  vector3_normalise u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .eps_we_i     (eps_we_i),
    .eps_wdata_i  (eps_wdata_i),
    .x_in_i       (x_in_i),
    .y_in_i       (y_in_i),
    .z_in_i       (z_in_i),
    .done_o       (done_o),
    .unit_x_o     (unit_x_o),
    .unit_y_o     (unit_y_o),
    .unit_z_o     (unit_z_o),
    .length_o     (length_o),
    .was_scaled_o (was_scaled_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #400000;
    $display("[vector3_normalise] ERROR");
    $finish;
  end

  function automatic longint unsigned sqrt_floor(longint unsigned s);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (s >= root + bitv) begin
        s = s - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic int unit_mag(longint unsigned mag, longint unsigned s);
    longint unsigned a;
    longint unsigned four_a2;
    longint unsigned t;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    a = mag << 14;
    four_a2 = 4 * a * a;
    lo = 0;
    hi = Q214One;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      t = 2 * mid - 1;
      if (t * t * s <= four_a2) lo = mid;
      else hi = mid - 1;
    end
    return int'(lo);
  endfunction

  function automatic unit_res_t normalise(logic signed [CompW-1:0] x,
                                          logic signed [CompW-1:0] y,
                                          logic signed [CompW-1:0] z,
                                          logic [CompW-1:0] eps);
    int c [3];
    int r [3];
    longint unsigned mag [3];
    longint unsigned s;
    longint unsigned eps_sq;
    unit_res_t res;
    c[0] = x;
    c[1] = y;
    c[2] = z;
    s = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = (c[i] < 0) ? longint'(-c[i]) : longint'(c[i]);
      s = s + mag[i] * mag[i];
    end
    eps_sq = longint'(eps) * longint'(eps);
    res.scaled = (s > eps_sq);
    for (int i = 0; i < 3; i++) begin
      if (res.scaled) begin
        r[i] = unit_mag(mag[i], s);
        if (c[i] < 0) r[i] = -r[i];
      end else begin
        r[i] = c[i] * 64;
        if (r[i] > 32767) r[i] = 32767;
        if (r[i] < -32768) r[i] = -32768;
      end
    end
    res.ux = r[0][CompW-1:0];
    res.uy = r[1][CompW-1:0];
    res.uz = r[2][CompW-1:0];
    res.len = RootW'(sqrt_floor(s));
    return res;
  endfunction

  task automatic report(string field, int got, int want);
    $display("mismatch %s: got %0d expected %0d", field, got, want);
    errors++;
  endtask

  always @(posedge clk_i) begin
    unit_res_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (unit_q.size() == 0) begin
          report("unexpected item", 1, 0);
        end else begin
          want = unit_q.pop_front();
          if (unit_x_o !== want.ux) report("unit_x", unit_x_o, want.ux);
          if (unit_y_o !== want.uy) report("unit_y", unit_y_o, want.uy);
          if (unit_z_o !== want.uz) report("unit_z", unit_z_o, want.uz);
          if (length_o !== want.len) report("length", length_o, want.len);
          if (was_scaled_o !== want.scaled) report("was_scaled", was_scaled_o, want.scaled);
        end
      end
      if (start_i && !busy_o) begin
        if (use_typed) unit_q.push_back(typed_res);
        else unit_q.push_back(normalise(x_in_i, y_in_i, z_in_i, eps_model));
      end
    end
  end

  task automatic send_vector(int x, int y, int z, bit typed, unit_res_t res);
    start_i <= 1'b1;
    x_in_i <= x[CompW-1:0];
    y_in_i <= y[CompW-1:0];
    z_in_i <= z[CompW-1:0];
    use_typed <= typed;
    typed_res <= res;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic pause(int cycles);
    start_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic drain_and_set_eps(int eps);
    pause(1);
    while (unit_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
    eps_we_i <= 1'b1;
    eps_wdata_i <= eps[CompW-1:0];
    @(posedge clk_i);
    eps_we_i <= 1'b0;
    eps_model = eps[CompW-1:0];
  endtask

  function automatic int pick_comp(int eps);
    int mode;
    int base;
    mode = $urandom_range(0, 6);
    base = (eps > 32767) ? 32767 : eps;
    case (mode)
      0: return $urandom_range(0, 65535) - 32768;
      1: return int'($urandom_range(0, 2047)) - 1024;
      2: return $urandom_range(0, 1) ? 32767 : -32768;
      3: return 0;
      4: return base - int'($urandom_range(0, 3));
      5: return int'($urandom_range(0, 15)) - 8;
      default: return ($urandom_range(0, 1) ? 1 : -1) * (base / 2 + int'($urandom_range(0, 2)));
    endcase
  endfunction

  initial begin
    int eps_set [6];
    int burst;
    unit_res_t res;
    eps_set[0] = 0;
    eps_set[1] = 65535;
    eps_set[2] = $urandom_range(1, 65534);
    eps_set[3] = 1;
    eps_set[4] = $urandom_range(128, 4096);
    eps_set[5] = $urandom_range(20000, 60000);
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < NumRows; i++) begin
      if (rows[i].eps != eps_model) drain_and_set_eps(rows[i].eps);
      res.ux = rows[i].ux[CompW-1:0];
      res.uy = rows[i].uy[CompW-1:0];
      res.uz = rows[i].uz[CompW-1:0];
      res.len = rows[i].len[RootW-1:0];
      res.scaled = rows[i].sc[0];
      send_vector(rows[i].x, rows[i].y, rows[i].z, rows[i].typed, res);
      if ($urandom_range(0, 2) == 0) pause($urandom_range(1, 3));
    end
    res = '0;
    for (int p = 0; p < 6; p++) begin
      drain_and_set_eps(eps_set[p]);
      for (int n = 0; n < 275; n += burst) begin
        burst = $urandom_range(1, 40);
        for (int k = 0; k < burst; k++) begin
          send_vector(pick_comp(eps_set[p]), pick_comp(eps_set[p]),
                      pick_comp(eps_set[p]), 1'b0, res);
        end
        if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 8));
      end
    end
    pause(1);
    while (unit_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
    if (errors == 0) begin
      $display("[vector3_normalise] OK");
    end else begin
      $display("[vector3_normalise] ERROR");
    end
    $finish;
  end
endmodule
